>>> sv/boot_serial_token_scanner_core_macros.svh
// Assertion helpers for the scanner RTL.
// Both expect clk and arst_n in scope.
`ifndef BOOT_SERIAL_TOKEN_SCANNER_CORE_MACROS_SVH
`define BOOT_SERIAL_TOKEN_SCANNER_CORE_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define BSTS_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// When the antecedent holds, the consequent must hold in the following cycle.
`define BSTS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/bsts_pkg.sv
`timescale 1ns / 1ps

package bsts_pkg;

	// Payload widths
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned LETTERS_W = 32;
	localparam int unsigned DIGITS_W  = 40;

	// Defaults for the top-level parameters
	localparam int unsigned TOKEN_LIMIT_DEF     = 33;
	localparam int unsigned CANDIDATE_SLOTS_DEF = 6;

	// Keyword and token shape
	localparam int unsigned KEY_LEN      = 6;
	localparam int unsigned KEY_PROG_W   = 3;
	localparam int unsigned KEPT_MAX     = 9;
	localparam int unsigned LETTER_CNT   = 4;
	localparam int unsigned DIGIT_CNT    = 5;
	localparam int unsigned KEPT_CNT_W   = 4;
	localparam logic [7:0]  CASE_OFFSET  = 8'd32;

	// Character codes
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_UP_A   = 8'h41;
	localparam logic [7:0] CH_UP_Z   = 8'h5A;
	localparam logic [7:0] CH_LO_A   = 8'h61;
	localparam logic [7:0] CH_LO_Z   = 8'h7A;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	// Lower-case keyword, first character at index 0
	localparam logic [KEY_LEN-1:0][7:0] KEY_CHARS =
		{8'h3A, 8'h6D, 8'h6F, 8'h72, 8'h64, 8'h63};

	// One candidate token as it moves along the cell row
	typedef struct packed {
		logic                         busy;
		logic                         skipping;
		logic [KEPT_CNT_W-1:0]        kept_cnt;
		logic [KEPT_MAX-1:0][7:0]     chars;
	} cand_t;

	// Control chain between neighboring cells
	typedef struct packed {
		logic gap;   // a free cell exists at or below this point
		logic won;   // a valid finisher exists at or below this point
	} chain_t;

	function automatic logic is_slash(input logic [7:0] b);
		return (b == CH_SLASH) || (b == CH_BSLASH);
	endfunction

	function automatic logic is_upper(input logic [7:0] b);
		return (b >= CH_UP_A) && (b <= CH_UP_Z);
	endfunction

	function automatic logic is_lower(input logic [7:0] b);
		return (b >= CH_LO_A) && (b <= CH_LO_Z);
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= CH_ZERO) && (b <= CH_NINE);
	endfunction

	function automatic logic is_alnum(input logic [7:0] b);
		return is_upper(b) || is_lower(b) || is_digit(b);
	endfunction

	function automatic logic is_stop(input logic [7:0] b);
		return (b == CH_SEMI) || (b == CH_CR) || (b == CH_LF) ||
			(b == CH_SPACE) || (b == CH_TAB) || (b == CH_NUL);
	endfunction

	function automatic logic [7:0] to_upper(input logic [7:0] b);
		return is_lower(b) ? (b - CASE_OFFSET) : b;
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] b);
		return is_upper(b) ? (b + CASE_OFFSET) : b;
	endfunction

endpackage

>>> sv/bsts_in_if.sv
`timescale 1ns / 1ps

interface bsts_in_if;
	logic                       valid;
	logic                       ready;
	logic [bsts_pkg::BYTE_W-1:0] data_byte;
	logic                       end_of_buffer;

	modport source (output valid, output data_byte, output end_of_buffer, input ready);
	modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

>>> sv/bsts_out_if.sv
`timescale 1ns / 1ps

interface bsts_out_if;
	logic                          valid;
	logic                          ready;
	logic                          serial_found;
	logic [bsts_pkg::LETTERS_W-1:0] serial_letters;
	logic [bsts_pkg::DIGITS_W-1:0]  serial_digits;

	modport source (output valid, output serial_found, output serial_letters,
		output serial_digits, input ready);
	modport sink   (input valid, input serial_found, input serial_letters,
		input serial_digits, output ready);
endinterface

>>> sv/bsts_keyword_matcher.sv
`timescale 1ns / 1ps

module bsts_keyword_matcher (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        advance,
	input  logic [bsts_pkg::BYTE_W-1:0] data_byte,
	input  logic                        end_of_buffer,
	output logic                        hit
);
	import bsts_pkg::*;

	logic [KEY_PROG_W-1:0] progress_q;
	logic [KEY_PROG_W-1:0] progress_nxt;
	logic [7:0]            low;
	logic [KEY_PROG_W-1:0] matched;

	// Case-folded compare against the next expected keyword character
	always_comb begin
		low     = to_lower(data_byte);
		matched = '0;
		hit     = 1'b0;
		if (low == KEY_CHARS[progress_q]) begin
			matched = progress_q + 1'b1;
		end else if (low == KEY_CHARS[0]) begin
			matched = KEY_PROG_W'(1);
		end
		if (matched == KEY_PROG_W'(KEY_LEN)) begin
			hit          = 1'b1;
			progress_nxt = '0;
		end else begin
			progress_nxt = matched;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			progress_q <= '0;
		end else if (advance) begin
			progress_q <= end_of_buffer ? '0 : progress_nxt;
		end
	end
endmodule

>>> sv/bsts_cell.sv
`timescale 1ns / 1ps

module bsts_cell #(
	parameter int unsigned TOKEN_LIMIT = bsts_pkg::TOKEN_LIMIT_DEF,
	parameter int unsigned RAW_W       = $clog2(TOKEN_LIMIT + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        advance,
	input  logic [bsts_pkg::BYTE_W-1:0] data_byte,
	input  logic                        end_of_buffer,
	// neighbor links
	input  bsts_pkg::chain_t            chain_in,
	output bsts_pkg::chain_t            chain_out,
	input  bsts_pkg::cand_t             upper_cand,
	input  logic [RAW_W-1:0]            upper_raw,
	output bsts_pkg::cand_t             post_cand,
	output logic [RAW_W-1:0]            post_raw,
	// winner report
	output logic                        win,
	output logic [bsts_pkg::KEPT_MAX-1:0][7:0] win_chars
);
	import bsts_pkg::*;

	cand_t            cand_q;
	logic [RAW_W-1:0] raw_q;
	cand_t            cand_nxt;
	logic [RAW_W-1:0] raw_nxt;
	logic             fin;
	logic             tok_ok;
	logic             shift;

	// Feed this byte to the held token
	always_comb begin
		post_cand = cand_q;
		post_raw  = raw_q;
		fin       = 1'b0;
		if (cand_q.busy) begin
			if (!(cand_q.skipping && is_slash(data_byte))) begin
				post_cand.skipping = 1'b0;
				if (is_stop(data_byte)) begin
					fin = 1'b1;
				end else begin
					post_raw = raw_q + 1'b1;
					if (is_slash(data_byte)) begin
						post_cand.kept_cnt = '0;
						post_cand.chars    = '0;
					end else if (is_alnum(data_byte) &&
						(cand_q.kept_cnt < KEPT_CNT_W'(KEPT_MAX))) begin
						for (int k = 0; k < KEPT_MAX; k++) begin
							if (cand_q.kept_cnt == KEPT_CNT_W'(k)) begin
								post_cand.chars[k] = to_upper(data_byte);
							end
						end
						post_cand.kept_cnt = cand_q.kept_cnt + 1'b1;
					end
					fin = (post_raw >= RAW_W'(TOKEN_LIMIT));
				end
			end
			if (end_of_buffer) begin
				fin = 1'b1;
			end
		end
		if (fin) begin
			post_cand.busy = 1'b0;
		end
	end

	// Token shape: four letters, then five digits
	always_comb begin
		tok_ok = (post_cand.kept_cnt == KEPT_CNT_W'(KEPT_MAX));
		for (int k = 0; k < LETTER_CNT; k++) begin
			tok_ok = tok_ok & is_upper(post_cand.chars[k]);
		end
		for (int k = LETTER_CNT; k < KEPT_MAX; k++) begin
			tok_ok = tok_ok & is_digit(post_cand.chars[k]);
		end
	end

	// Oldest valid finisher wins; lower cells are older
	assign win             = fin && tok_ok && !chain_in.won;
	assign win_chars       = win ? post_cand.chars : '0;
	assign chain_out.won   = chain_in.won | (fin && tok_ok);

	// Compact toward the bottom when a free cell lies at or below
	assign chain_out.gap = chain_in.gap | !post_cand.busy;
	assign shift         = chain_out.gap;
	assign cand_nxt      = shift ? upper_cand : post_cand;
	assign raw_nxt       = shift ? upper_raw : post_raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q <= '0;
			raw_q  <= '0;
		end else if (advance) begin
			cand_q <= cand_nxt;
			raw_q  <= raw_nxt;
		end
	end
endmodule

>>> sv/boot_serial_token_scanner_core.sv
`timescale 1ns / 1ps
// Scans a byte stream for the keyword "cdrom:" (any case, overlapping hits
// included) and extracts the first boot serial of the form AAAA##### that
// follows one. One byte is taken every clock cycle. Each hit starts a
// candidate in a row of CANDIDATE_SLOTS cells kept in age order; every cycle
// all cells see the byte, finished cells drop out and the row closes up by one
// cell toward the oldest end. A hit is dropped when every cell is still
// busy or when it comes on the byte flagged end_of_buffer. The result
// transaction leaves from an output register in the cycle after that byte
// is taken; the input stalls only while that register holds a result not
// yet taken. The next region may start on the following byte.
`include "boot_serial_token_scanner_core_macros.svh"

module boot_serial_token_scanner_core #(
	parameter int unsigned TOKEN_LIMIT     = bsts_pkg::TOKEN_LIMIT_DEF,
	parameter int unsigned CANDIDATE_SLOTS = bsts_pkg::CANDIDATE_SLOTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	bsts_in_if.sink           stream,
	bsts_out_if.source        report
);
	import bsts_pkg::*;

	localparam int unsigned RAW_W = $clog2(TOKEN_LIMIT + 1);

	logic                           advance;
	logic                           last;
	logic                           hit;
	cand_t                          new_cand;
	cand_t  [CANDIDATE_SLOTS-1:0]   post_v;
	logic   [CANDIDATE_SLOTS-1:0][RAW_W-1:0] raw_v;
	chain_t [CANDIDATE_SLOTS:0]     chain_v;
	logic   [CANDIDATE_SLOTS-1:0]   win_v;
	logic   [CANDIDATE_SLOTS-1:0][KEPT_MAX-1:0][7:0] win_chars_v;
	logic   [KEPT_MAX-1:0][7:0]     win_chars;
	logic                           any_win;
	logic   [CANDIDATE_SLOTS-1:0]   busy_v;

	logic                           held_q;
	logic   [KEPT_MAX-1:0][7:0]     held_chars_q;
	logic   [KEPT_MAX-1:0][7:0]     final_chars;
	logic                           out_valid_q;
	logic                           out_found_q;
	logic   [LETTERS_W-1:0]         out_letters_q;
	logic   [DIGITS_W-1:0]          out_digits_q;

	// Input handshake: blocked only by an untaken result
	assign stream.ready = !out_valid_q || report.ready;
	assign advance      = stream.valid && stream.ready;
	assign last         = stream.end_of_buffer;

	bsts_keyword_matcher u_matcher (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.data_byte     (stream.data_byte),
		.end_of_buffer (last),
		.hit           (hit)
	);

	// Fresh candidate enters at the youngest end of the row
	always_comb begin
		new_cand          = '0;
		new_cand.busy     = hit && !last;
		new_cand.skipping = 1'b1;
	end

	assign chain_v[0] = '0;

	for (genvar i = 0; i < CANDIDATE_SLOTS; i++) begin : g_cell
		cand_t            upper_cand;
		logic [RAW_W-1:0] upper_raw;

		if (i == CANDIDATE_SLOTS - 1) begin : g_top
			assign upper_cand = new_cand;
			assign upper_raw  = '0;
		end else begin : g_mid
			assign upper_cand = post_v[i+1];
			assign upper_raw  = raw_v[i+1];
		end

		bsts_cell #(
			.TOKEN_LIMIT (TOKEN_LIMIT),
			.RAW_W       (RAW_W)
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.advance       (advance),
			.data_byte     (stream.data_byte),
			.end_of_buffer (last),
			.chain_in      (chain_v[i]),
			.chain_out     (chain_v[i+1]),
			.upper_cand    (upper_cand),
			.upper_raw     (upper_raw),
			.post_cand     (post_v[i]),
			.post_raw      (raw_v[i]),
			.win           (win_v[i]),
			.win_chars     (win_chars_v[i])
		);

		assign busy_v[i] = post_v[i].busy;
	end

	// At most one cell reports a win; gather its characters
	always_comb begin
		win_chars = '0;
		for (int i = 0; i < CANDIDATE_SLOTS; i++) begin
			win_chars = win_chars | win_chars_v[i];
		end
	end
	assign any_win = chain_v[CANDIDATE_SLOTS].won;

	// Serial held for the current region
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q       <= 1'b0;
			held_chars_q <= '0;
		end else if (advance) begin
			if (last) begin
				held_q       <= 1'b0;
				held_chars_q <= '0;
			end else if (any_win && !held_q) begin
				held_q       <= 1'b1;
				held_chars_q <= win_chars;
			end
		end
	end

	assign final_chars = held_q ? held_chars_q : win_chars;

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last) begin
			out_valid_q <= 1'b1;
		end else if (report.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last) begin
			out_found_q   <= held_q || any_win;
			out_letters_q <= {final_chars[0], final_chars[1], final_chars[2],
				final_chars[3]};
			out_digits_q  <= {final_chars[4], final_chars[5], final_chars[6],
				final_chars[7], final_chars[8]};
		end
	end

	assign report.valid          = out_valid_q;
	assign report.serial_found   = out_found_q;
	assign report.serial_letters = out_letters_q;
	assign report.serial_digits  = out_digits_q;

	// Checks
	`BSTS_ASSERT_ALWAYS(a_single_winner, $onehot0(win_v), "more than one cell won")
	`BSTS_ASSERT_ALWAYS(a_win_matches_chain, (win_v != '0) == any_win,
		"winner chain disagrees with cell flags")
	`BSTS_ASSERT_NEXT(a_result_after_last, advance && last, out_valid_q,
		"no result after last byte")
	`BSTS_ASSERT_ALWAYS(a_row_empty_on_last, !(advance && last) || (busy_v == '0),
		"candidate survives the last byte")
endmodule
